FILE: rtl/core/clgs_pkg.sv
// Shared constants, types and helpers for the continuous life grid step unit.
`timescale 1ns / 1ps

package clgs_pkg;

    localparam int GRID_W  = 64;
    localparam int GRID_H  = 64;
    localparam int X_W     = 6;
    localparam int Y_W     = 6;
    localparam int ADDR_W  = 12;
    localparam int LIFE_W  = 24;
    localparam int ACC_W   = LIFE_W + 3;
    localparam int DIST_W  = LIFE_W + 2;
    localparam int PROD_W  = LIFE_W + DIST_W;
    localparam int LOSS_W  = PROD_W - 16;
    localparam int NEXT_W  = LOSS_W + 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [2:0] REG_TARGET_AVG = 3'd0;
    localparam logic [2:0] REG_TOLERANCE  = 3'd1;
    localparam logic [2:0] REG_DECAY_GAIN = 3'd2;
    localparam logic [2:0] REG_LIFE_FLOOR = 3'd3;
    localparam logic [2:0] REG_GROWTH     = 3'd4;
    localparam logic [2:0] REG_USE_DIAG   = 3'd5;

    typedef struct packed {
        logic signed [LIFE_W-1:0] target_avg;
        logic signed [LIFE_W-1:0] tolerance;
        logic signed [LIFE_W-1:0] decay_gain;
        logic signed [LIFE_W-1:0] life_floor;
        logic signed [LIFE_W-1:0] growth;
        logic                     use_diagonals;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(x) * ADDR_W'(GRID_H) + ADDR_W'(y);
        return a;
    endfunction

endpackage

FILE: rtl/core/clgs_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module clgs_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/clgs_update.sv
// Per-cell life update datapath: distance, gain multiply, saturate and floor.
`timescale 1ns / 1ps

module clgs_update (
    input  logic                               clk,
    input  clgs_pkg::cfg_t                     cfg,
    input  logic signed [clgs_pkg::LIFE_W-1:0] life,
    input  logic signed [clgs_pkg::LIFE_W-1:0] avg,
    output logic signed [clgs_pkg::LIFE_W-1:0] result
);

    logic signed [clgs_pkg::LIFE_W:0]     diff;
    logic signed [clgs_pkg::DIST_W-1:0]   mag;
    logic signed [clgs_pkg::DIST_W-1:0]   excess;
    logic signed [clgs_pkg::DIST_W-1:0]   excess_reg;
    logic signed [clgs_pkg::LIFE_W-1:0]   life1_reg;
    logic signed [clgs_pkg::PROD_W-1:0]   prod_reg;
    logic signed [clgs_pkg::LIFE_W-1:0]   life2_reg;
    logic signed [clgs_pkg::LOSS_W-1:0]   loss;
    logic signed [clgs_pkg::NEXT_W-1:0]   sum;
    logic signed [clgs_pkg::LIFE_W-1:0]   sat;
    logic                                 over;
    logic                                 under;

    // Stage one: distance of the neighbor average from the preferred one.
    always_comb
    begin
        diff   = {cfg.target_avg[clgs_pkg::LIFE_W-1], cfg.target_avg}
               - {avg[clgs_pkg::LIFE_W-1], avg};
        mag    = diff[clgs_pkg::LIFE_W] ? -{diff[clgs_pkg::LIFE_W], diff}
                                        : {diff[clgs_pkg::LIFE_W], diff};
        excess = mag - {{2{cfg.tolerance[clgs_pkg::LIFE_W-1]}}, cfg.tolerance};
    end

    always_ff @(posedge clk)
    begin
        excess_reg <= excess;
        life1_reg  <= life;
        prod_reg   <= cfg.decay_gain * excess_reg;
        life2_reg  <= life1_reg;
    end

    // Stage three: the low 16 product bits drop off, which floors toward minus infinity.
    always_comb
    begin
        loss  = prod_reg[clgs_pkg::PROD_W-1:16];
        sum   = {{(clgs_pkg::NEXT_W - clgs_pkg::LIFE_W){life2_reg[clgs_pkg::LIFE_W-1]}},
                 life2_reg}
              - {{2{loss[clgs_pkg::LOSS_W-1]}}, loss}
              + {{(clgs_pkg::NEXT_W - clgs_pkg::LIFE_W){cfg.growth[clgs_pkg::LIFE_W-1]}},
                 cfg.growth};
        over  = !sum[clgs_pkg::NEXT_W-1] && (|sum[clgs_pkg::NEXT_W-2:clgs_pkg::LIFE_W-1]);
        under = sum[clgs_pkg::NEXT_W-1] && !(&sum[clgs_pkg::NEXT_W-2:clgs_pkg::LIFE_W-1]);
        if (over)
        begin
            sat = {1'b0, {(clgs_pkg::LIFE_W-1){1'b1}}};
        end
        else if (under)
        begin
            sat = {1'b1, {(clgs_pkg::LIFE_W-1){1'b0}}};
        end
        else
        begin
            sat = sum[clgs_pkg::LIFE_W-1:0];
        end
        result = (sat < cfg.life_floor) ? '0 : sat;
    end

endmodule

FILE: rtl/core/continuous_life_grid_step_unit.sv
// Top level of the continuous life grid step unit: sequencer, grid memories and ports.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  operation, cell_x, cell_y, life_in
// m_*       out        m_tvalid/m_tready  life_out, step_done
// cfg_*     in         cfg_we             cfg_index selects, cfg_data value
//
// After reset the life memory is swept to zero at one cell per cycle, all 4096 cells,
// and no transaction is accepted during the sweep.
// A write or an unused operation gives its result in the cycle after acceptance; a read
// first passes through ST_READ. A generation averages over four or eight neighbors,
// bounded by the life memory's single read port, then updates in ST_UPD0 to ST_UPD3.
// A new transaction is accepted only once the result register has been emptied.

module continuous_life_grid_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], cell_x[7:2], cell_y[13:8], life_in[37:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // life_out[23:0], step_done[24]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_AVG   = 3'd3;
    localparam logic [2:0] ST_UPD0  = 3'd4;
    localparam logic [2:0] ST_UPD1  = 3'd5;
    localparam logic [2:0] ST_UPD2  = 3'd6;
    localparam logic [2:0] ST_UPD3  = 3'd7;

    localparam int LW = clgs_pkg::LIFE_W;
    localparam int AW = clgs_pkg::ADDR_W;
    localparam int XW = clgs_pkg::X_W;
    localparam int YW = clgs_pkg::Y_W;

    // Input transaction fields.
    logic [1:0]           in_op;
    logic [XW-1:0]        in_x;
    logic [YW-1:0]        in_y;
    logic [LW-1:0]        in_life;
    logic                 in_on_grid;
    logic                 accept;

    assign in_op      = s_tdata[1:0];
    assign in_x       = s_tdata[7:2];
    assign in_y       = s_tdata[13:8];
    assign in_life    = s_tdata[37:14];
    assign in_on_grid = ({1'b0, in_x} < (XW+1)'(clgs_pkg::GRID_W))
                     && ({1'b0, in_y} < (YW+1)'(clgs_pkg::GRID_H));

    // Control and configuration state.
    logic [2:0]               state_reg, state_next;
    logic [XW-1:0]            cx_reg, cx_next;
    logic [YW-1:0]            cy_reg, cy_next;
    logic [3:0]               k_reg, k_next;
    logic signed [clgs_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic                     out_valid_reg, out_valid_next;
    logic [LW-1:0]            out_life_reg, out_life_next;
    logic                     out_done_reg, out_done_next;
    clgs_pkg::cfg_t           cfg_reg;

    // Memory ports.
    logic                     life_we;
    logic [AW-1:0]            life_waddr;
    logic [LW-1:0]            life_wdata;
    logic [AW-1:0]            life_raddr;
    logic [LW-1:0]            life_rdata;
    logic                     avg_we;
    logic [AW-1:0]            avg_addr;
    logic [LW-1:0]            avg_wdata;
    logic [LW-1:0]            avg_rdata;
    logic signed [LW-1:0]     upd_result;

    // Neighbor addressing for the averaging pass.
    logic [XW-1:0]            xp, xm, nx;
    logic [YW-1:0]            yp, ym, ny;
    logic [3:0]               n_nbr;
    logic                     last_cell;
    logic [AW-1:0]            here;
    logic signed [clgs_pkg::ACC_W-1:0] total;

    assign here      = clgs_pkg::cell_addr(cx_reg, cy_reg);
    assign last_cell = (cx_reg == XW'(clgs_pkg::GRID_W - 1))
                    && (cy_reg == YW'(clgs_pkg::GRID_H - 1));
    assign n_nbr     = cfg_reg.use_diagonals ? 4'd8 : 4'd4;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_done_reg, out_life_reg};

    always_comb
    begin
        xp = (cx_reg == XW'(clgs_pkg::GRID_W - 1)) ? '0 : cx_reg + 1'b1;
        xm = (cx_reg == '0) ? XW'(clgs_pkg::GRID_W - 1) : cx_reg - 1'b1;
        yp = (cy_reg == YW'(clgs_pkg::GRID_H - 1)) ? '0 : cy_reg + 1'b1;
        ym = (cy_reg == '0) ? YW'(clgs_pkg::GRID_H - 1) : cy_reg - 1'b1;
        case (k_reg)
            4'd0:    begin nx = xp;     ny = cy_reg; end
            4'd1:    begin nx = xm;     ny = cy_reg; end
            4'd2:    begin nx = cx_reg; ny = yp;     end
            4'd3:    begin nx = cx_reg; ny = ym;     end
            4'd4:    begin nx = xp;     ny = yp;     end
            4'd5:    begin nx = xp;     ny = ym;     end
            4'd6:    begin nx = xm;     ny = yp;     end
            default: begin nx = xm;     ny = ym;     end
        endcase
    end

    // The running sum plus the neighbor whose read data is arriving now.
    assign total = acc_reg + {{(clgs_pkg::ACC_W - LW){life_rdata[LW-1]}}, life_rdata};

    always_comb
    begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_life_next  = out_life_reg;
        out_done_next  = out_done_reg;
        life_we        = 1'b0;
        life_waddr     = here;
        life_wdata     = upd_result;
        life_raddr     = here;
        avg_we         = 1'b0;
        avg_wdata      = cfg_reg.use_diagonals ? total[LW+2:3] : total[LW+1:2];

        if (cy_reg == YW'(clgs_pkg::GRID_H - 1))
        begin
            cy_next = '0;
            cx_next = cx_reg + 1'b1;
        end
        else
        begin
            cy_next = cy_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                life_we    = 1'b1;
                life_wdata = '0;
                if (last_cell)
                begin
                    cx_next    = '0;
                    cy_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cx_next    = '0;
                cy_next    = '0;
                k_next     = '0;
                acc_next   = '0;
                life_raddr = clgs_pkg::cell_addr(in_x, in_y);
                life_waddr = clgs_pkg::cell_addr(in_x, in_y);
                life_wdata = in_life;
                if (accept)
                begin
                    out_life_next = '0;
                    out_done_next = 1'b0;
                    case (in_op)
                        clgs_pkg::OP_WRITE:
                        begin
                            life_we        = in_on_grid;
                            out_valid_next = 1'b1;
                        end
                        clgs_pkg::OP_READ:
                        begin
                            rd_ok_next = in_on_grid;
                            state_next = ST_READ;
                        end
                        clgs_pkg::OP_STEP:
                        begin
                            state_next = ST_AVG;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_life_next  = rd_ok_reg ? life_rdata : '0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_AVG:
            begin
                // Reads go out for k below the neighbor count; data returns the next cycle.
                life_raddr = clgs_pkg::cell_addr(nx, ny);
                if (k_reg == n_nbr)
                begin
                    avg_we   = 1'b1;
                    acc_next = '0;
                    k_next   = '0;
                    if (last_cell)
                    begin
                        cx_next    = '0;
                        cy_next    = '0;
                        state_next = ST_UPD0;
                    end
                end
                else
                begin
                    cx_next = cx_reg;
                    cy_next = cy_reg;
                    k_next  = k_reg + 1'b1;
                    if (k_reg != '0)
                    begin
                        acc_next = total;
                    end
                end
            end
            ST_UPD0:
            begin
                cx_next    = cx_reg;
                cy_next    = cy_reg;
                state_next = ST_UPD1;
            end
            ST_UPD1:
            begin
                cx_next    = cx_reg;
                cy_next    = cy_reg;
                state_next = ST_UPD2;
            end
            ST_UPD2:
            begin
                cx_next    = cx_reg;
                cy_next    = cy_reg;
                state_next = ST_UPD3;
            end
            ST_UPD3:
            begin
                life_we    = 1'b1;
                state_next = ST_UPD0;
                if (last_cell)
                begin
                    cx_next        = '0;
                    cy_next        = '0;
                    out_life_next  = '0;
                    out_done_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign avg_addr = here;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cx_reg        <= '0;
            cy_reg        <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    clgs_pkg::REG_TARGET_AVG: cfg_reg.target_avg    <= cfg_data;
                    clgs_pkg::REG_TOLERANCE:  cfg_reg.tolerance     <= cfg_data;
                    clgs_pkg::REG_DECAY_GAIN: cfg_reg.decay_gain    <= cfg_data;
                    clgs_pkg::REG_LIFE_FLOOR: cfg_reg.life_floor    <= cfg_data;
                    clgs_pkg::REG_GROWTH:     cfg_reg.growth        <= cfg_data;
                    clgs_pkg::REG_USE_DIAG:   cfg_reg.use_diagonals <= cfg_data[0];
                    default:                  cfg_reg               <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_life_reg <= out_life_next;
        out_done_reg <= out_done_next;
    end

    clgs_ram #(
        .DATA_W (LW),
        .ADDR_W (AW)
    ) u_life_ram (
        .clk   (clk),
        .we    (life_we),
        .waddr (life_waddr),
        .wdata (life_wdata),
        .raddr (life_raddr),
        .rdata (life_rdata)
    );

    clgs_ram #(
        .DATA_W (LW),
        .ADDR_W (AW)
    ) u_avg_ram (
        .clk   (clk),
        .we    (avg_we),
        .waddr (avg_addr),
        .wdata (avg_wdata),
        .raddr (avg_addr),
        .rdata (avg_rdata)
    );

    clgs_update u_update (
        .clk    (clk),
        .cfg    (cfg_reg),
        .life   (life_rdata),
        .avg    (avg_rdata),
        .result (upd_result)
    );

endmodule

FILE: verif/continuous_life_grid_step_unit_tb.sv
// Self-checking testbench for the continuous life grid step unit.
`timescale 1ns / 1ps

module continuous_life_grid_step_unit_tb;

    // The package names operations 0 to 2 only; 3 must leave everything alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint LIFE_HI = 64'sd8388607;
    localparam longint LIFE_LO = -64'sd8388608;
    localparam int LW = clgs_pkg::LIFE_W;
    localparam int GW = clgs_pkg::GRID_W;
    localparam int GH = clgs_pkg::GRID_H;

    typedef struct {
        logic [1:0]                   op;
        logic [clgs_pkg::X_W-1:0]     x;
        logic [clgs_pkg::Y_W-1:0]     y;
        logic signed [LW-1:0]         life;
    } grid_cmd_t;

    typedef struct {
        logic [LW-1:0]     life_out;
        logic              step_done;
    } grid_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    continuous_life_grid_step_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Commands waiting to be driven and replies waiting to be seen.
    grid_cmd_t   cmd_queue[$];
    grid_reply_t reply_queue[$];
    int          fail_count = 0;

    // Our own copy of the grid and of the configuration registers.
    logic signed [LW-1:0] life_grid [GW*GH];
    logic signed [LW-1:0] avg_grid  [GW*GH];
    logic signed [LW-1:0] cfg_target_avg = '0;
    logic signed [LW-1:0] cfg_tolerance = '0;
    logic signed [LW-1:0] cfg_decay_gain = '0;
    logic signed [LW-1:0] cfg_life_floor = '0;
    logic signed [LW-1:0] cfg_growth = '0;
    logic                 cfg_diag = 1'b0;

    initial begin
        for (int i = 0; i < GW*GH; i++)
        begin
            life_grid[i] = '0;
            avg_grid[i] = '0;
        end
    end

    function automatic longint grid_at(int x, int y);
        return longint'(life_grid[((x + GW) % GW) * GH + ((y + GH) % GH)]);
    endfunction

    // One generation: neighbor averages from the old grid first, then the update.
    task automatic evolve_grid();
        longint sum, diff, excess, loss, nxt;
        for (int x = 0; x < GW; x++)
        begin
            for (int y = 0; y < GH; y++)
            begin
                sum = grid_at(x+1, y) + grid_at(x-1, y) + grid_at(x, y+1) + grid_at(x, y-1);
                if (cfg_diag)
                begin
                    sum += grid_at(x+1, y+1) + grid_at(x+1, y-1)
                         + grid_at(x-1, y+1) + grid_at(x-1, y-1);
                end
                // Arithmetic shift on a signed longint rounds toward minus infinity.
                avg_grid[x*GH + y] = LW'(sum >>> (cfg_diag ? 3 : 2));
            end
        end
        for (int i = 0; i < GW*GH; i++)
        begin
            diff = longint'(cfg_target_avg) - longint'(avg_grid[i]);
            if (diff < 0)
                diff = -diff;
            excess = diff - longint'(cfg_tolerance);
            loss = (longint'(cfg_decay_gain) * excess) >>> 16;
            nxt = longint'(life_grid[i]) - loss + longint'(cfg_growth);
            if (nxt > LIFE_HI)
                nxt = LIFE_HI;
            if (nxt < LIFE_LO)
                nxt = LIFE_LO;
            if (nxt < longint'(cfg_life_floor))
                nxt = 0;
            life_grid[i] = LW'(nxt);
        end
    endtask

    // Work out the reply one accepted command causes and update the grid copy.
    task automatic predict_reply(input grid_cmd_t cmd);
        grid_reply_t r;
        r.life_out = '0;
        r.step_done = 1'b0;
        case (cmd.op)
            clgs_pkg::OP_WRITE: life_grid[cmd.x*GH + cmd.y] = cmd.life;
            clgs_pkg::OP_READ:  r.life_out = life_grid[cmd.x*GH + cmd.y];
            clgs_pkg::OP_STEP:
            begin
                evolve_grid();
                r.step_done = 1'b1;
            end
            default: ;
        endcase
        reply_queue.push_back(r);
    endtask

    // Accepted input transactions and output transactions, both seen at the
    // rising edge. The reply is checked first so that the queue order never
    // depends on which block the simulator runs first.
    logic cmd_taken = 1'b0;
    always @(posedge clk)
    begin
        grid_cmd_t   c;
        grid_reply_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_queue.size() == 0)
            begin
                $error("output transaction with no reply expected: tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                e = reply_queue.pop_front();
                if (m_tdata[23:0] !== e.life_out)
                begin
                    $error("life_out expected %h actual %h", e.life_out, m_tdata[23:0]);
                    fail_count++;
                end
                if (m_tdata[24] !== e.step_done)
                begin
                    $error("step_done expected %0b actual %0b", e.step_done, m_tdata[24]);
                    fail_count++;
                end
            end
        end
        cmd_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.op = s_tdata[1:0];
            c.x = s_tdata[7:2];
            c.y = s_tdata[13:8];
            c.life = s_tdata[37:14];
            predict_reply(c);
        end
    end

    // Gap lengths: mostly short, sometimes long, often none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: a command stays on the bus until it has been taken.
    int src_gap = 0;
    always @(negedge clk)
    begin
        grid_cmd_t c;
        if (!(s_tvalid && !cmd_taken))
        begin
            if (src_gap > 0)
            begin
                s_tvalid = 1'b0;
                src_gap--;
            end
            else if (cmd_queue.size() > 0)
            begin
                c = cmd_queue.pop_front();
                s_tdata = {2'b00, c.life, c.y, c.x, c.op};
                s_tvalid = 1'b1;
                src_gap = pick_gap();
            end
            else
            begin
                s_tvalid = 1'b0;
            end
        end
    end

    // Downstream side: stalls of random length between ready stretches.
    int sink_gap = 0;
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            m_tready = 1'b0;
            sink_gap--;
        end
        else
        begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_gap = pick_gap();
        end
    end

    // Configuration writes happen only while nothing is in flight.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            clgs_pkg::REG_TARGET_AVG: cfg_target_avg = val;
            clgs_pkg::REG_TOLERANCE:  cfg_tolerance = val;
            clgs_pkg::REG_DECAY_GAIN: cfg_decay_gain = val;
            clgs_pkg::REG_LIFE_FLOOR: cfg_life_floor = val;
            clgs_pkg::REG_GROWTH:     cfg_growth = val;
            clgs_pkg::REG_USE_DIAG:   cfg_diag = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || s_tvalid || reply_queue.size() != 0)
            @(negedge clk);
    endtask

    // Coordinates cluster near the edges so that writes, reads and the
    // wrapped neighborhoods overlap.
    function automatic logic [5:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return (r < 4) ? 6'($urandom_range(0, 2)) : 6'($urandom_range(61, 63));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [23:0] pick_life();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($signed($urandom_range(0, 4*65536)) - 2*65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic grid_cmd_t make_cmd(input logic [1:0] op, input logic [5:0] x,
                                           input logic [5:0] y, input logic [23:0] v);
        grid_cmd_t c;
        c.op = op;
        c.x = x;
        c.y = y;
        c.life = v;
        return c;
    endfunction

    function automatic logic [23:0] pick_reg(input int mode);
        case (mode)
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            default:
                if ($urandom_range(0, 3) == 0)
                    return 24'($urandom);
                else
                    return 24'($signed($urandom_range(0, 2*65536)) - 65536);
        endcase
    endfunction

    initial begin
        int r;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: extremes, every operation, corners.
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd0, 6'd0, 24'h7FFFFF));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd63, 6'd63, 24'h800000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd63, 6'd0, 24'h010000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd0, 6'd63, 24'hFF0000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd1, 6'd0, 24'hAAAAAA));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, 6'd42, 6'd21, 24'h555555));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd0, 6'd0, 24'h000000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd63, 6'd63, 24'hFFFFFF));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd42, 6'd21, 24'h000000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd21, 6'd42, 24'h000000));
        cmd_queue.push_back(make_cmd(OP_UNUSED, 6'd63, 6'd63, 24'hFFFFFF));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd1, 6'd0, 24'h000000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_STEP, 6'd0, 6'd0, 24'h000000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd0, 6'd0, 24'h000000));
        cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, 6'd63, 6'd0, 24'h000000));
        wait_idle();

        // Random phases: one with all-maximum registers, one with all-minimum,
        // the rest mixed. Every phase rewrites every register.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(clgs_pkg::REG_TARGET_AVG, pick_reg(ph));
            write_reg(clgs_pkg::REG_TOLERANCE, pick_reg(ph));
            write_reg(clgs_pkg::REG_DECAY_GAIN, pick_reg(ph));
            write_reg(clgs_pkg::REG_LIFE_FLOOR, (ph == 0) ? 24'h800000 : pick_reg(ph));
            write_reg(clgs_pkg::REG_GROWTH, pick_reg(ph));
            write_reg(clgs_pkg::REG_USE_DIAG, (ph == 1 || ph == 3) ? 24'd1 : 24'd0);
            for (int i = 0; i < 22; i++)
            begin
                r = $urandom_range(0, 99);
                if (i == 10 || i == 20)
                    cmd_queue.push_back(make_cmd(clgs_pkg::OP_STEP, 6'($urandom),
                                                 6'($urandom), 24'($urandom)));
                else if (r < 55)
                    cmd_queue.push_back(make_cmd(clgs_pkg::OP_WRITE, pick_coord(),
                                                 pick_coord(), pick_life()));
                else if (r < 95)
                    cmd_queue.push_back(make_cmd(clgs_pkg::OP_READ, pick_coord(),
                                                 pick_coord(), 24'($urandom)));
                else
                    cmd_queue.push_back(make_cmd(OP_UNUSED, 6'($urandom), 6'($urandom),
                                                 24'($urandom)));
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Nine generations over up to eight neighbors each, plus the clearing sweep
    // and stalls, fit well inside this bound.
    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
